// ===== design/scbp_pkg.sv =====
// Package for the size class block pool: command and status codes, defaults.
// Used by size_class_block_pool; depends on nothing.
package scbp_pkg;
	localparam int SMALL_BLOCKS_D  = 16;
	localparam int MEDIUM_BLOCKS_D = 8;
	localparam int LARGE_BLOCKS_D  = 4;
	localparam int OWNER_BITS_D    = 8;
	localparam logic [31:0] TIMEOUT_RESET = 32'd300000;

	localparam logic [2:0] CMD_ALLOC   = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_SWEEP   = 3'd2;
	localparam logic [2:0] CMD_CHECK   = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_HEAP     = 3'd2;
	localparam logic [2:0] ST_EXHAUST  = 3'd3;
	localparam logic [2:0] ST_NOT_HELD = 3'd4;

	localparam logic [1:0] REG_SMALL   = 2'd0;
	localparam logic [1:0] REG_MEDIUM  = 2'd1;
	localparam logic [1:0] REG_LARGE   = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;
endpackage

// ===== design/scbp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module scbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/size_class_block_pool.sv =====
// Size class block pool: allocate, release, check, reclaim sweep and clear.
// Allocate, release, check, clear: the result is registered on transfer, then DONE raises out_valid.
// Sweep: one block a cycle through the owner/stamp RAMs, then DONE raises out_valid.
// One command at a time; next input is taken once the result is transferred.
// Reset clears in-use flags, totals, counters and loads register defaults.
// Owner and stamp RAMs are not cleared; only the data of held blocks is used.
module size_class_block_pool
	import scbp_pkg::*;
#(
	parameter int SMALL_BLOCKS  = SMALL_BLOCKS_D,
	parameter int MEDIUM_BLOCKS = MEDIUM_BLOCKS_D,
	parameter int LARGE_BLOCKS  = LARGE_BLOCKS_D,
	parameter int OWNER_BITS    = OWNER_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [15:0] request_size,
	input  logic [1:0]  block_class,
	input  logic [3:0]  block_index,
	input  logic [7:0]  owner_id,
	input  logic [7:0]  dead_owner,
	input  logic        dead_owner_valid,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  out_class,
	output logic [3:0]  out_index,
	output logic [15:0] block_bytes,
	output logic [31:0] total_allocated,
	output logic [31:0] peak_usage,
	output logic [31:0] alloc_count,
	output logic [31:0] release_count,
	output logic [31:0] fragment_count,
	output logic [4:0]  reclaimed_count
);
	localparam int TOTAL = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
	localparam int AW    = $clog2(TOTAL + 1);
	localparam int MB    = SMALL_BLOCKS;
	localparam int LB    = SMALL_BLOCKS + MEDIUM_BLOCKS;

	typedef enum logic [1:0] {IDLE, SWEEP, DONE} state_t;
	state_t state_q;

	logic [15:0] small_q, medium_q, large_q;
	logic [31:0] timeout_q;
	logic [TOTAL-1:0] used_q;
	logic [31:0] held_q, peak_q, grants_q, returns_q, misses_q;
	logic [7:0]  dead_q;
	logic        dead_ok_q;
	logic [31:0] now_q;
	logic [AW-1:0] ptr_q, ptr_s1;
	logic        rd_s1;
	logic [4:0]  recl_q;

	logic [OWNER_BITS-1:0] own_rd;
	logic [31:0] stamp_rd;
	logic [AW-1:0] raddr;
	logic        we;
	logic [AW-1:0] waddr;

	// first free block of the chosen class, and the held block named by class/index
	logic [1:0]  acls;
	logic        afound;
	logic [AW-1:0] aidx;
	logic [15:0] abytes;
	logic        hvalid;
	logic [AW-1:0] haddr;
	logic [15:0] hbytes;

	always_comb begin
		int lo, hi;
		acls = 2'd3;
		if (request_size <= small_q) acls = 2'd0;
		else if (request_size <= medium_q) acls = 2'd1;
		else if (request_size <= large_q) acls = 2'd2;
		unique case (acls)
			2'd0: begin lo = 0; hi = SMALL_BLOCKS; abytes = small_q; end
			2'd1: begin lo = MB; hi = LB; abytes = medium_q; end
			2'd2: begin lo = LB; hi = TOTAL; abytes = large_q; end
			default: begin lo = 0; hi = 0; abytes = 16'd0; end
		endcase
		afound = 1'b0;
		aidx = '0;
		for (int k = TOTAL - 1; k >= 0; k--) begin
			if (k >= lo && k < hi && !used_q[k]) begin
				afound = 1'b1;
				aidx = AW'(k);
			end
		end
		hvalid = 1'b0;
		haddr = '0;
		hbytes = 16'd0;
		unique case (block_class)
			2'd0: if (32'(block_index) < SMALL_BLOCKS) begin
				hvalid = 1'b1; haddr = AW'(block_index); hbytes = small_q;
			end
			2'd1: if (32'(block_index) < MEDIUM_BLOCKS) begin
				hvalid = 1'b1; haddr = AW'(MB + 32'(block_index)); hbytes = medium_q;
			end
			2'd2: if (32'(block_index) < LARGE_BLOCKS) begin
				hvalid = 1'b1; haddr = AW'(LB + 32'(block_index)); hbytes = large_q;
			end
			default: ;
		endcase
		if (hvalid && !used_q[haddr]) hvalid = 1'b0;
	end

	logic accept;
	assign in_ready = (state_q == IDLE) && !out_valid;
	assign accept = in_valid && in_ready;
	assign we = accept && command == CMD_ALLOC && request_size != 16'd0
		&& acls != 2'd3 && afound;
	assign waddr = aidx;
	assign raddr = ptr_q;

	scbp_ram #(.WIDTH(OWNER_BITS), .DEPTH(TOTAL)) u_owner (
		.clk, .we, .waddr(waddr[$clog2(TOTAL)-1:0]), .wdata(OWNER_BITS'(owner_id)),
		.raddr(raddr[$clog2(TOTAL)-1:0]), .rdata(own_rd));
	scbp_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_stamp (
		.clk, .we, .waddr(waddr[$clog2(TOTAL)-1:0]), .wdata(now_ms),
		.raddr(raddr[$clog2(TOTAL)-1:0]), .rdata(stamp_rd));

	logic [15:0] sbytes;
	logic        hit;
	always_comb begin
		if (32'(ptr_s1) < MB) sbytes = small_q;
		else if (32'(ptr_s1) < LB) sbytes = medium_q;
		else sbytes = large_q;
		hit = rd_s1 && used_q[ptr_s1[$clog2(TOTAL)-1:0]] &&
			((dead_ok_q && own_rd == OWNER_BITS'(dead_q)) ||
			 (now_q - stamp_rd) > timeout_q);
	end

	logic [31:0] nheld;
	assign nheld = held_q + 32'(abytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			small_q <= 16'd64; medium_q <= 16'd256; large_q <= 16'd1024;
			timeout_q <= TIMEOUT_RESET;
			used_q <= '0;
			held_q <= '0; peak_q <= '0; grants_q <= '0; returns_q <= '0; misses_q <= '0;
			out_valid <= 1'b0;
			rd_s1 <= 1'b0;
			ptr_q <= '0; ptr_s1 <= '0;
			recl_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SMALL:   small_q <= cfg_data[15:0];
					REG_MEDIUM:  medium_q <= cfg_data[15:0];
					REG_LARGE:   large_q <= cfg_data[15:0];
					REG_TIMEOUT: timeout_q <= cfg_data;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: if (accept) begin
					dead_q <= dead_owner; dead_ok_q <= dead_owner_valid; now_q <= now_ms;
					status <= ST_OK; out_class <= 2'd0; out_index <= 4'd0;
					block_bytes <= 16'd0; recl_q <= '0;
					state_q <= DONE;
					priority case (command)
						CMD_ALLOC: begin
							if (request_size == 16'd0) status <= ST_ZERO;
							else if (acls == 2'd3) begin
								status <= ST_HEAP; misses_q <= misses_q + 32'd1;
							end else if (!afound) begin
								status <= ST_EXHAUST; misses_q <= misses_q + 32'd1;
							end else begin
								used_q[aidx] <= 1'b1;
								held_q <= nheld;
								grants_q <= grants_q + 32'd1;
								if (nheld > peak_q) peak_q <= nheld;
								out_class <= acls;
								unique case (acls)
									2'd0: out_index <= 4'(aidx);
									2'd1: out_index <= 4'(aidx - AW'(MB));
									default: out_index <= 4'(aidx - AW'(LB));
								endcase
								block_bytes <= abytes;
							end
						end
						CMD_RELEASE, CMD_CHECK: begin
							if (!hvalid) status <= ST_NOT_HELD;
							else if (command == CMD_RELEASE) begin
								used_q[haddr] <= 1'b0;
								held_q <= held_q - 32'(hbytes);
								returns_q <= returns_q + 32'd1;
								block_bytes <= hbytes;
							end
						end
						CMD_SWEEP: begin
							ptr_q <= '0;
							state_q <= SWEEP;
						end
						CMD_CLEAR: begin
							used_q <= '0; held_q <= '0; grants_q <= '0; returns_q <= '0;
						end
						default: ;
					endcase
				end
				SWEEP: begin
					rd_s1 <= 32'(ptr_q) < TOTAL;
					ptr_s1 <= ptr_q;
					if (32'(ptr_q) < TOTAL) ptr_q <= ptr_q + AW'(1);
					if (hit) begin
						used_q[ptr_s1[$clog2(TOTAL)-1:0]] <= 1'b0;
						held_q <= held_q - 32'(sbytes);
						misses_q <= misses_q + 32'd1;
						recl_q <= recl_q + 5'd1;
					end
					if (!rd_s1 && 32'(ptr_q) == TOTAL) state_q <= DONE;
				end
				DONE: begin
					rd_s1 <= 1'b0;
					out_valid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign total_allocated = held_q;
	assign peak_usage = peak_q;
	assign alloc_count = grants_q;
	assign release_count = returns_q;
	assign fragment_count = misses_q;
	assign reclaimed_count = recl_q;
endmodule
